// ===== sv/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant violated");

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

`endif

// ===== sv/rdd_pkg.sv =====
// Types and constants of the reliable datagram deframer.
// Used by the parser, the result queue and the top level.
`default_nettype none

package rdd_pkg;

    // Result kinds.
    localparam logic [2:0] RK_NAME     = 3'd0;
    localparam logic [2:0] RK_LENGTH   = 3'd1;
    localparam logic [2:0] RK_PAYLOAD  = 3'd2;
    localparam logic [2:0] RK_ACK_RX   = 3'd3;
    localparam logic [2:0] RK_SEND_ACK = 3'd4;
    localparam logic [2:0] RK_STALE    = 3'd5;
    localparam logic [2:0] RK_TRUNC    = 3'd6;

    // Result queue geometry.
    localparam int QDEPTH  = 8;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int LEVEL_W = QPTR_W + 1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_byte;
        logic [7:0]  record_length;
        logic        payload_last;
        logic [63:0] sender_id;
        logic [63:0] confirm_id;
        logic [63:0] local_id;
        logic        untracked;
        logic        run_last;
    } rdd_result_t;

    // Results produced by one byte: a count of zero, one or two, and the items.
    typedef struct packed {
        logic [1:0]  n;
        rdd_result_t r0;
        rdd_result_t r1;
    } rdd_push_t;

endpackage

`default_nettype wire

// ===== sv/rdd_in_if.sv =====
// Input channel of the deframer: one datagram byte per transfer.
// Depends on nothing but the valid/ready handshake.
`default_nettype none

interface rdd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       datagram_end;

    modport source (output valid, output data_byte, output datagram_end, input ready);
    modport sink   (input valid, input data_byte, input datagram_end, output ready);
endinterface

`default_nettype wire

// ===== sv/rdd_out_if.sv =====
// Result channel of the deframer: one result item per transfer.
// Depends on nothing but the valid/ready handshake.
`default_nettype none

interface rdd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [7:0]  record_length;
    logic        payload_last;
    logic [63:0] sender_id;
    logic [63:0] confirm_id;
    logic [63:0] local_id;
    logic        untracked;
    logic        run_last;

    modport source (output valid, output kind, output out_byte, output record_length,
                    output payload_last, output sender_id, output confirm_id,
                    output local_id, output untracked, output run_last, input ready);
    modport sink   (input valid, input kind, input out_byte, input record_length,
                    input payload_last, input sender_id, input confirm_id,
                    input local_id, input untracked, input run_last, output ready);
endinterface

`default_nettype wire

// ===== sv/rdd_parser.sv =====
// Input register, datagram parser and sender table of the deframer.
// Depends on rdd_pkg, rdd_in_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rdd_parser #(
    parameter int SENDERS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    rdd_in_if.sink                    din,
    input  logic [rdd_pkg::LEVEL_W-1:0] level,
    output rdd_pkg::rdd_push_t        push
);
    import rdd_pkg::*;

    localparam logic [1:0] DG_UNREL    = 2'd0;
    localparam logic [1:0] DG_RELIABLE = 2'd1;
    localparam logic [1:0] DG_ACK      = 2'd2;

    localparam logic [5:0] HDR_LEN_RELIABLE = 6'd24;
    localparam logic [5:0] HDR_LEN_SHORT    = 6'd16;

    typedef enum logic [5:0] {
        PH_TYPE    = 6'b000001,
        PH_HEADER  = 6'b000010,
        PH_NAME    = 6'b000100,
        PH_LEN     = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_SKIP    = 6'b100000
    } phase_t;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_end_reg;

    phase_t      phase_reg, phase_next;
    logic [4:0]  hc_reg, hc_next;
    logic [1:0]  kind_reg, kind_next;
    logic [63:0] cs_reg, cs_next;
    logic [63:0] ss_reg, ss_next;
    logic [63:0] own_reg, own_next;
    logic [7:0]  bl_reg, bl_next;
    logic        acc_reg, acc_next;
    logic        untr_reg, untr_next;

    logic [63:0]        tbl_sender_reg [SENDERS];
    logic [63:0]        tbl_confirm_reg [SENDERS];
    logic [SENDERS-1:0] tbl_valid_reg;

    logic [SENDERS-1:0] hit_vec;
    logic [SENDERS-1:0] free_vec;
    logic [SENDERS-1:0] sel_vec;
    logic [63:0]        hit_confirm;
    logic               any_hit;
    logic               any_free;
    logic               stale;
    logic               hdr_done;
    logic               tbl_we;

    logic [1:0]  n;
    logic [2:0]  k0, k1;
    logic [7:0]  byte0, len0;
    logic        last0;
    logic [7:0]  b;
    logic        e;

    assign b = s1_byte_reg;
    assign e = s1_end_reg;

    // Two results per byte in flight at most, for the registered byte and the new one.
    assign din.ready = ({1'b0, level} + (s1_valid_reg ? (LEVEL_W + 1)'(2) : '0))
                       <= (LEVEL_W + 1)'(QDEPTH - 2);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg <= din.valid && din.ready;
        end
    end

    always_ff @(posedge clk) begin
        if (din.valid && din.ready) begin
            s1_byte_reg <= din.data_byte;
            s1_end_reg  <= din.datagram_end;
        end
    end

    // Senders are stored once, so at most one entry matches.
    always_comb begin
        hit_confirm = '0;
        for (int i = 0; i < SENDERS; i++) begin
            hit_vec[i] = tbl_valid_reg[i] && (tbl_sender_reg[i] == ss_reg);
            hit_confirm = hit_confirm | (hit_vec[i] ? tbl_confirm_reg[i] : 64'd0);
        end
    end

    assign free_vec = ~tbl_valid_reg & (tbl_valid_reg + 1'b1);
    assign any_hit  = |hit_vec;
    assign any_free = |free_vec;
    assign sel_vec  = any_hit ? hit_vec : free_vec;
    assign stale    = any_hit && (cs_reg < hit_confirm);
    assign hdr_done = ({1'b0, hc_reg} + 6'd1)
                      >= ((kind_reg == DG_RELIABLE) ? HDR_LEN_RELIABLE : HDR_LEN_SHORT);

    always_comb begin
        phase_next = phase_reg;
        hc_next    = hc_reg;
        kind_next  = kind_reg;
        cs_next    = cs_reg;
        ss_next    = ss_reg;
        own_next   = own_reg;
        bl_next    = bl_reg;
        acc_next   = acc_reg;
        untr_next  = untr_reg;
        n          = 2'd0;
        k0         = RK_TRUNC;
        k1         = RK_TRUNC;
        byte0      = 8'd0;
        len0       = 8'd0;
        last0      = 1'b0;
        tbl_we     = 1'b0;
        if (s1_valid_reg) begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    kind_next  = (b == 8'd2) ? DG_ACK : ((b == 8'd1) ? DG_RELIABLE : DG_UNREL);
                    hc_next    = 5'd0;
                    cs_next    = 64'd0;
                    ss_next    = 64'd0;
                    bl_next    = 8'd0;
                    acc_next   = 1'b0;
                    untr_next  = 1'b0;
                    phase_next = PH_HEADER;
                    if (e)
                    begin
                        n  = 2'd1;
                        k0 = RK_TRUNC;
                    end
                end
                PH_HEADER:
                begin
                    if (kind_reg == DG_UNREL)
                    begin
                        if (hc_reg < 5'd8)
                            ss_next = {ss_reg[55:0], b};
                        else
                            own_next = {own_reg[55:0], b};
                    end
                    else
                    begin
                        if (hc_reg < 5'd8)
                            cs_next = {cs_reg[55:0], b};
                        else if (hc_reg < 5'd16)
                            ss_next = {ss_reg[55:0], b};
                        else
                            own_next = {own_reg[55:0], b};
                    end
                    hc_next = hc_reg + 5'd1;
                    if (!hdr_done)
                    begin
                        if (e)
                        begin
                            n  = 2'd1;
                            k0 = RK_TRUNC;
                        end
                    end
                    else if (kind_reg == DG_ACK)
                    begin
                        n          = 2'd1;
                        k0         = RK_ACK_RX;
                        phase_next = PH_SKIP;
                    end
                    else if (kind_reg == DG_RELIABLE)
                    begin
                        if (stale)
                        begin
                            n          = 2'd1;
                            k0         = RK_STALE;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            tbl_we     = 1'b1;
                            acc_next   = 1'b1;
                            phase_next = PH_NAME;
                            if (!any_hit && !any_free)
                                untr_next = 1'b1;
                            if (e)
                            begin
                                n  = 2'd1;
                                k0 = RK_SEND_ACK;
                            end
                        end
                    end
                    else
                    begin
                        phase_next = PH_NAME;
                    end
                end
                PH_NAME:
                begin
                    if (b != 8'd0)
                    begin
                        n     = 2'd1;
                        k0    = RK_NAME;
                        byte0 = b;
                        if (e)
                            n = 2'd2;
                    end
                    else
                    begin
                        phase_next = PH_LEN;
                        if (e)
                        begin
                            n  = 2'd1;
                            k0 = RK_TRUNC;
                        end
                    end
                end
                PH_LEN:
                begin
                    n     = 2'd1;
                    k0    = RK_LENGTH;
                    len0  = b;
                    last0 = (b == 8'd0);
                    if (b == 8'd0)
                    begin
                        phase_next = PH_NAME;
                        if (e && acc_reg)
                        begin
                            n  = 2'd2;
                            k1 = RK_SEND_ACK;
                        end
                    end
                    else
                    begin
                        bl_next    = b;
                        phase_next = PH_PAYLOAD;
                        if (e)
                            n = 2'd2;
                    end
                end
                PH_PAYLOAD:
                begin
                    n     = 2'd1;
                    k0    = RK_PAYLOAD;
                    byte0 = b;
                    last0 = (bl_reg <= 8'd1);
                    if (bl_reg <= 8'd1)
                    begin
                        bl_next    = 8'd0;
                        phase_next = PH_NAME;
                        if (e && acc_reg)
                        begin
                            n  = 2'd2;
                            k1 = RK_SEND_ACK;
                        end
                    end
                    else
                    begin
                        bl_next = bl_reg - 8'd1;
                        if (e)
                            n = 2'd2;
                    end
                end
                PH_SKIP:
                begin
                end
                default:
                begin
                end
            endcase
            if (e)
                phase_next = PH_TYPE;
        end
    end

    always_comb begin
        push.n                  = n;
        push.r0.kind            = k0;
        push.r0.out_byte        = byte0;
        push.r0.record_length   = len0;
        push.r0.payload_last    = last0;
        push.r0.sender_id       = ss_next;
        push.r0.confirm_id      = ((k0 == RK_ACK_RX) || (k0 == RK_SEND_ACK) || (k0 == RK_STALE))
                                  ? cs_next : 64'd0;
        push.r0.local_id        = own_next;
        push.r0.untracked       = untr_next;
        push.r0.run_last        = (n == 2'd1);
        push.r1.kind            = k1;
        push.r1.out_byte        = 8'd0;
        push.r1.record_length   = 8'd0;
        push.r1.payload_last    = 1'b0;
        push.r1.sender_id       = ss_next;
        push.r1.confirm_id      = (k1 == RK_SEND_ACK) ? cs_next : 64'd0;
        push.r1.local_id        = own_next;
        push.r1.untracked       = untr_next;
        push.r1.run_last        = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg     <= PH_TYPE;
            hc_reg        <= 5'd0;
            kind_reg      <= DG_UNREL;
            cs_reg        <= 64'd0;
            ss_reg        <= 64'd0;
            own_reg       <= 64'd0;
            bl_reg        <= 8'd0;
            acc_reg       <= 1'b0;
            untr_reg      <= 1'b0;
            tbl_valid_reg <= '0;
        end
        else begin
            phase_reg <= phase_next;
            hc_reg    <= hc_next;
            kind_reg  <= kind_next;
            cs_reg    <= cs_next;
            ss_reg    <= ss_next;
            own_reg   <= own_next;
            bl_reg    <= bl_next;
            acc_reg   <= acc_next;
            untr_reg  <= untr_next;
            if (tbl_we && !any_hit)
                tbl_valid_reg <= tbl_valid_reg | free_vec;
        end
    end

    always_ff @(posedge clk) begin
        for (int i = 0; i < SENDERS; i++) begin
            if (tbl_we && sel_vec[i]) begin
                tbl_sender_reg[i]  <= ss_reg;
                tbl_confirm_reg[i] <= cs_reg;
            end
        end
    end

    `ASSERT_ALWAYS(a_hit_unique, clk, rst_n, $onehot0(hit_vec))
    `ASSERT_IMPLIES(a_acc_reliable, clk, rst_n, acc_reg, kind_reg == DG_RELIABLE)
    `ASSERT_IMPLIES(a_payload_left, clk, rst_n, phase_reg == PH_PAYLOAD, bl_reg != 8'd0)
    `ASSERT_ALWAYS(a_queue_room, clk, rst_n, level <= LEVEL_W'(QDEPTH))

endmodule

`default_nettype wire

// ===== sv/rdd_out_queue.sv =====
// Result queue of the deframer: takes up to two results a cycle, delivers one.
// Depends on rdd_pkg and rdd_out_if.
`default_nettype none

module rdd_out_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rdd_pkg::rdd_push_t          push,
    output logic [rdd_pkg::LEVEL_W-1:0] level,
    rdd_out_if.source                   dout
);
    import rdd_pkg::*;

    rdd_result_t         mem_reg [QDEPTH];
    rdd_result_t         head;
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [LEVEL_W-1:0]  count_reg;
    logic                pop;

    assign level      = count_reg;
    assign dout.valid = (count_reg != '0);
    assign pop        = dout.valid && dout.ready;
    assign head       = mem_reg[rd_ptr_reg];

    assign dout.kind          = head.kind;
    assign dout.out_byte      = head.out_byte;
    assign dout.record_length = head.record_length;
    assign dout.payload_last  = head.payload_last;
    assign dout.sender_id     = head.sender_id;
    assign dout.confirm_id    = head.confirm_id;
    assign dout.local_id      = head.local_id;
    assign dout.untracked     = head.untracked;
    assign dout.run_last      = head.run_last;

    always_ff @(posedge clk) begin
        if (push.n != 2'd0)
            mem_reg[wr_ptr_reg] <= push.r0;
        if (push.n == 2'd2)
            mem_reg[wr_ptr_reg + 1'b1] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push.n);
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(pop);
            count_reg  <= count_reg + LEVEL_W'(push.n) - LEVEL_W'(pop);
        end
    end

endmodule

`default_nettype wire

// ===== sv/reliable_datagram_deframer.sv =====
// Reliable datagram deframer: takes one datagram byte per transfer and returns the
// header events and record fields of each datagram as result items, one per transfer.
// A byte is accepted in every cycle while the queue has room; it is registered in the
// input register, then parsed and checked against the sender table (all entries
// compared in parallel) in the next cycle, and its zero, one or two results enter an
// eight-entry result queue, from which the first result of a byte is offered. The
// result port delivers one item a cycle while the receiver is ready, so a run of
// bytes with two results each is paced by the result port, and input is held off
// while the queue cannot take two more results per byte in flight.
// Depends on rdd_pkg, rdd_in_if, rdd_out_if, rdd_parser and rdd_out_queue.
`default_nettype none

module reliable_datagram_deframer #(
    parameter int SENDERS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    rdd_in_if.sink    din,
    rdd_out_if.source dout
);
    import rdd_pkg::*;

    rdd_push_t          push;
    logic [LEVEL_W-1:0] level;

    rdd_parser #(
        .SENDERS (SENDERS)
    ) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .level (level),
        .push  (push)
    );

    rdd_out_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .level (level),
        .dout  (dout)
    );

endmodule

`default_nettype wire
